/* design/mmrq_pkg.sv */
// Shared types and constants for the int8 2x2 matrix-multiply requantization core.
// No dependencies; used by the core and its port checker.
package mmrq_pkg;

	// Payload widths fixed by the interface
	localparam int DATA_W     = 8;
	localparam int ACC_W      = 32;
	localparam int INDEX_W    = 12;
	localparam int PAIR_NUM_W = 9;

	// Configuration port geometry
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	// Register field widths
	localparam int NUM_COLS_W  = 13;
	localparam int NUM_PAIRS_W = 10;
	localparam int SHIFT_W     = 5;

	// Register map, indexed by paddr[3:2]
	typedef enum logic [REG_IDX_W-1:0] {
		REG_NUM_COLS   = 2'd0,
		REG_NUM_PAIRS  = 2'd1,
		REG_BIAS_SHIFT = 2'd2,
		REG_OUT_SHIFT  = 2'd3
	} reg_idx_t;

	// Request kinds
	typedef enum logic {
		KIND_LOAD   = 1'b0,
		KIND_WEIGHT = 1'b1
	} kind_t;

	// Saturation bounds of the int8 result
	localparam logic signed [ACC_W-1:0] SAT_MIN = -32'sd128;
	localparam logic signed [ACC_W-1:0] SAT_MAX = 32'sd127;

endpackage

/* design/mmrq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mmrq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/int8_matmul_2x2_requant_core.sv */
// Top level of the int8 2x2 matrix-multiply core with shift requantization.
// Depends on mmrq_pkg and mmrq_ram.

// Usage: load both activation columns first (kind 0, one element pair per request,
// addressed by col_index), then stream weight requests (kind 1), one element of the
// even and the odd channel row per request, num_cols requests per channel pair. The
// activation store is read at the accept edge and the four MACs run in the next cycle,
// so loads and weight requests that do not close a pair are taken one per cycle. The
// request that closes a pair holds req_ready low while it is in stage 1 (MAC) and then
// stage 2, where the accumulators are requantized into the result register once that
// register is free; a result left waiting on res_ready stalls the next closing request
// in stage 2, and with it further requests. Activation store entries must be loaded before they
// are used.
module int8_matmul_2x2_requant_core #(
	parameter int MAX_COLS  = 4096,
	parameter int MAX_PAIRS = 512
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [mmrq_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [mmrq_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [mmrq_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready,
	// Request channel
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  logic                                  kind,
	input  logic [mmrq_pkg::INDEX_W-1:0]          col_index,
	input  logic signed [mmrq_pkg::DATA_W-1:0]    act_first,
	input  logic signed [mmrq_pkg::DATA_W-1:0]    act_second,
	input  logic signed [mmrq_pkg::DATA_W-1:0]    weight_even,
	input  logic signed [mmrq_pkg::DATA_W-1:0]    weight_odd,
	input  logic signed [mmrq_pkg::DATA_W-1:0]    bias_even,
	input  logic signed [mmrq_pkg::DATA_W-1:0]    bias_odd,
	// Result channel
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic signed [mmrq_pkg::DATA_W-1:0]    out_even_first,
	output logic signed [mmrq_pkg::DATA_W-1:0]    out_odd_first,
	output logic signed [mmrq_pkg::DATA_W-1:0]    out_even_second,
	output logic signed [mmrq_pkg::DATA_W-1:0]    out_odd_second,
	output logic [mmrq_pkg::PAIR_NUM_W-1:0]       pair_number
);

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int CCNT_W = COL_W + 1;
	localparam int PAIR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int PCNT_W = PAIR_W + 1;
	localparam int DW     = mmrq_pkg::DATA_W;
	localparam int AW     = mmrq_pkg::ACC_W;

	// Configuration registers
	logic [mmrq_pkg::NUM_COLS_W-1:0]  num_cols_q;
	logic [mmrq_pkg::NUM_PAIRS_W-1:0] num_pairs_q;
	logic [mmrq_pkg::SHIFT_W-1:0]     bias_shift_q;
	logic [mmrq_pkg::SHIFT_W-1:0]     rq_shift_q;
	logic                             cfg_we;
	mmrq_pkg::reg_idx_t               cfg_idx;

	// Position counters
	logic [COL_W-1:0]  col_pos_q;
	logic [PAIR_W-1:0] pair_pos_q;
	logic [CCNT_W-1:0] cols_eff;
	logic [PCNT_W-1:0] pairs_eff;
	logic              pair_first;
	logic              pair_last;

	// Handshake and store access
	logic                accept;
	logic                weight_acc;
	logic                store_we;
	logic [2*DW-1:0]     store_rdata;

	// Stage 1: MAC
	logic                  s1_valid_s1;
	logic                  s1_first_s1;
	logic                  s1_last_s1;
	logic [PAIR_W-1:0]     s1_pair_s1;
	logic signed [DW-1:0]  w_even_s1;
	logic signed [DW-1:0]  w_odd_s1;
	logic signed [DW-1:0]  b_even_s1;
	logic signed [DW-1:0]  b_odd_s1;

	// Stage 2: requantize
	logic              s2_valid_s2;
	logic [PAIR_W-1:0] s2_pair_s2;
	logic              s2_move;

	// Accumulators
	logic signed [AW-1:0] acc_ef_q;
	logic signed [AW-1:0] acc_of_q;
	logic signed [AW-1:0] acc_es_q;
	logic signed [AW-1:0] acc_os_q;
	logic signed [AW-1:0] rnd;
	logic signed [AW-1:0] seed_even;
	logic signed [AW-1:0] seed_odd;
	logic signed [AW-1:0] base_ef;
	logic signed [AW-1:0] base_of;
	logic signed [AW-1:0] base_es;
	logic signed [AW-1:0] base_os;
	logic signed [DW-1:0] a_first;
	logic signed [DW-1:0] a_second;
	logic signed [2*DW-1:0] prod_ef;
	logic signed [2*DW-1:0] prod_of;
	logic signed [2*DW-1:0] prod_es;
	logic signed [2*DW-1:0] prod_os;

	// Result register
	logic res_valid_q;

	// Arithmetic shift right by the requantization shift, then saturate to int8
	function automatic logic signed [DW-1:0] requant(
		input logic signed [AW-1:0]                acc,
		input logic [mmrq_pkg::SHIFT_W-1:0]        sh
	);
		logic signed [AW-1:0] r;
		r = acc >>> sh;
		if (r < mmrq_pkg::SAT_MIN) begin
			return DW'(mmrq_pkg::SAT_MIN);
		end else if (r > mmrq_pkg::SAT_MAX) begin
			return DW'(mmrq_pkg::SAT_MAX);
		end
		return DW'(r);
	endfunction

	// Configuration write and readback
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = mmrq_pkg::reg_idx_t'(paddr[mmrq_pkg::REG_IDX_W+1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q   <= mmrq_pkg::NUM_COLS_W'(1);
			num_pairs_q  <= mmrq_pkg::NUM_PAIRS_W'(1);
			bias_shift_q <= '0;
			rq_shift_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				mmrq_pkg::REG_NUM_COLS:   num_cols_q   <= pwdata[mmrq_pkg::NUM_COLS_W-1:0];
				mmrq_pkg::REG_NUM_PAIRS:  num_pairs_q  <= pwdata[mmrq_pkg::NUM_PAIRS_W-1:0];
				mmrq_pkg::REG_BIAS_SHIFT: bias_shift_q <= pwdata[mmrq_pkg::SHIFT_W-1:0];
				mmrq_pkg::REG_OUT_SHIFT:  rq_shift_q   <= pwdata[mmrq_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			mmrq_pkg::REG_NUM_COLS:   prdata = mmrq_pkg::APB_DATA_W'(num_cols_q);
			mmrq_pkg::REG_NUM_PAIRS:  prdata = mmrq_pkg::APB_DATA_W'(num_pairs_q);
			mmrq_pkg::REG_BIAS_SHIFT: prdata = mmrq_pkg::APB_DATA_W'(bias_shift_q);
			mmrq_pkg::REG_OUT_SHIFT:  prdata = mmrq_pkg::APB_DATA_W'(rq_shift_q);
			default:                  prdata = '0;
		endcase
	end

	// Clamp counts to their legal ranges
	always_comb begin
		if (num_cols_q == '0) begin
			cols_eff = CCNT_W'(1);
		end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
			cols_eff = CCNT_W'(MAX_COLS);
		end else begin
			cols_eff = CCNT_W'(num_cols_q);
		end
		if (num_pairs_q == '0) begin
			pairs_eff = PCNT_W'(1);
		end else if (32'(num_pairs_q) > 32'(MAX_PAIRS)) begin
			pairs_eff = PCNT_W'(MAX_PAIRS);
		end else begin
			pairs_eff = PCNT_W'(num_pairs_q);
		end
	end

	// Hold requests while a closing item is in the MAC or requantize stage
	assign req_ready  = !(s1_valid_s1 && s1_last_s1) && !s2_valid_s2;
	assign accept     = req_valid && req_ready;
	assign weight_acc = accept && (kind == mmrq_pkg::KIND_WEIGHT);
	assign store_we   = accept && (kind == mmrq_pkg::KIND_LOAD)
		&& (32'(col_index) < 32'(MAX_COLS));

	assign pair_first = (col_pos_q == '0);
	assign pair_last  = (CCNT_W'(col_pos_q) + CCNT_W'(1)) >= cols_eff;

	// Advance column and pair positions on each weight request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q  <= '0;
			pair_pos_q <= '0;
		end else if (weight_acc) begin
			if (pair_last) begin
				col_pos_q <= '0;
				if ((PCNT_W'(pair_pos_q) + PCNT_W'(1)) >= pairs_eff) begin
					pair_pos_q <= '0;
				end else begin
					pair_pos_q <= pair_pos_q + PAIR_W'(1);
				end
			end else begin
				col_pos_q <= col_pos_q + COL_W'(1);
			end
		end
	end

	// Activation store: low byte first column, high byte second column
	mmrq_ram #(
		.WIDTH (2 * DW),
		.DEPTH (MAX_COLS)
	) u_act_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (COL_W'(col_index)),
		.wdata ({act_second, act_first}),
		.raddr (col_pos_q),
		.rdata (store_rdata)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s1_first_s1 <= 1'b0;
			s1_last_s1  <= 1'b0;
		end else begin
			s1_valid_s1 <= weight_acc;
			if (weight_acc) begin
				s1_first_s1 <= pair_first;
				s1_last_s1  <= pair_last;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (weight_acc) begin
			s1_pair_s1 <= pair_pos_q;
			w_even_s1  <= weight_even;
			w_odd_s1   <= weight_odd;
			b_even_s1  <= bias_even;
			b_odd_s1   <= bias_odd;
		end
	end

	// Seed: shifted bias plus rounding half-unit
	always_comb begin
		if (rq_shift_q != '0) begin
			rnd = AW'(1) <<< (rq_shift_q - mmrq_pkg::SHIFT_W'(1));
		end else begin
			rnd = '0;
		end
		seed_even = (AW'(b_even_s1) <<< bias_shift_q) + rnd;
		seed_odd  = (AW'(b_odd_s1) <<< bias_shift_q) + rnd;
	end

	assign a_first  = store_rdata[DW-1:0];
	assign a_second = store_rdata[2*DW-1:DW];
	assign prod_ef  = w_even_s1 * a_first;
	assign prod_es  = w_even_s1 * a_second;
	assign prod_of  = w_odd_s1 * a_first;
	assign prod_os  = w_odd_s1 * a_second;

	assign base_ef = s1_first_s1 ? seed_even : acc_ef_q;
	assign base_es = s1_first_s1 ? seed_even : acc_es_q;
	assign base_of = s1_first_s1 ? seed_odd  : acc_of_q;
	assign base_os = s1_first_s1 ? seed_odd  : acc_os_q;

	// Multiply-accumulate, wrapping in 32 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_ef_q <= '0;
			acc_of_q <= '0;
			acc_es_q <= '0;
			acc_os_q <= '0;
		end else if (s1_valid_s1) begin
			acc_ef_q <= base_ef + AW'(prod_ef);
			acc_of_q <= base_of + AW'(prod_of);
			acc_es_q <= base_es + AW'(prod_es);
			acc_os_q <= base_os + AW'(prod_os);
		end
	end

	// Stage 2: hold until the result register is free
	assign s2_move = s2_valid_s2 && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s1_valid_s1 && s1_last_s1) begin
			s2_valid_s2 <= 1'b1;
		end else if (s2_move) begin
			s2_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1 && s1_last_s1) begin
			s2_pair_s2 <= s1_pair_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_move) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_even_first  <= requant(acc_ef_q, rq_shift_q);
			out_odd_first   <= requant(acc_of_q, rq_shift_q);
			out_even_second <= requant(acc_es_q, rq_shift_q);
			out_odd_second  <= requant(acc_os_q, rq_shift_q);
			pair_number     <= mmrq_pkg::PAIR_NUM_W'(s2_pair_s2);
		end
	end

	assign res_valid = res_valid_q;

endmodule

/* design/mmrq_checker.sv */
// Port-level checker for int8_matmul_2x2_requant_core, bound to the top level.
// Depends on mmrq_pkg.
module mmrq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                kind,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic signed [mmrq_pkg::DATA_W-1:0]  out_even_first,
	input logic signed [mmrq_pkg::DATA_W-1:0]  out_odd_first,
	input logic signed [mmrq_pkg::DATA_W-1:0]  out_even_second,
	input logic signed [mmrq_pkg::DATA_W-1:0]  out_odd_second,
	input logic [mmrq_pkg::PAIR_NUM_W-1:0]     pair_number,
	input logic                                pready
);

	// Configuration port never stalls
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// A stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_even_first)
			&& $stable(out_odd_first) && $stable(out_even_second)
			&& $stable(out_odd_second) && $stable(pair_number))
		else $error("result changed while stalled");

	// A new result traces back to an accepted weight request
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_valid && req_ready
			&& (kind == mmrq_pkg::KIND_WEIGHT), 3))
		else $error("result without a closing weight request");

	// Requests are held while a result is being requantized
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!req_ready, 1))
		else $error("request accepted during requantization");

endmodule

bind int8_matmul_2x2_requant_core mmrq_checker u_mmrq_checker (.*);
